// File: rtl/cvrd_pkg.sv
// Shared types and constants for the cell voltage response decoder.
package cvrd_pkg;

   localparam logic [7:0]  POSITIVE_RESPONSE = 8'h61;
   localparam logic [7:0]  GROUP_RESET       = 8'd2;
   localparam logic [6:0]  COUNT_LIMIT       = 7'd127;
   localparam logic [22:0] SUM_LIMIT         = 23'h7FFFFF;
   localparam int          QUEUE_DEPTH       = 4;
   localparam int          QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } cvrd_req_type;

   typedef struct packed {
      logic        is_summary;
      logic [6:0]  cell_index;
      logic [15:0] cell_mv;
      logic        decode_ok;
      logic [6:0]  reading_count;
      logic [15:0] min_mv;
      logic [15:0] max_mv;
      logic [15:0] spread_mv;
      logic [22:0] sum_mv;
   } cvrd_rsp_type;

   // Work handed from the byte classifier to the statistics stage.
   typedef struct packed {
      logic        is_cell;
      logic        last;
      logic [15:0] mv;
   } cvrd_op_type;

endpackage

// File: rtl/cvrd_front.sv
// Byte classifier: header check, byte pairing and the per-payload reading limit.
module cvrd_front
   import cvrd_pkg::*;
#(
   parameter int ECHO_LEN  = 2,
   parameter int MAX_CELLS = 96
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   expected_group,
   input  logic         req_valid,
   output logic         req_stall,
   input  cvrd_req_type req_data,
   output logic         op_push,
   output cvrd_op_type  op_data,
   input  logic         op_full
);

   localparam int POS_W  = $clog2(ECHO_LEN + 1);
   localparam int SEEN_W = $clog2(MAX_CELLS + 1);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              hdr_ok_ff, hdr_ok_in;
   logic              phase_ff, phase_in;
   logic [7:0]        pend_ff, pend_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic              accept;
   logic              is_cell;

   assign req_stall = op_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      pos_in    = pos_ff;
      hdr_ok_in = hdr_ok_ff;
      phase_in  = phase_ff;
      pend_in   = pend_ff;
      seen_in   = seen_ff;
      is_cell   = 1'b0;
      if (pos_ff < POS_W'(ECHO_LEN)) begin
         if (pos_ff == '0) begin
            hdr_ok_in = (req_data.data_byte == POSITIVE_RESPONSE);
         end else if (pos_ff == POS_W'(1)) begin
            hdr_ok_in = hdr_ok_ff && (req_data.data_byte == expected_group);
         end
         pos_in = pos_ff + POS_W'(1);
      end else if (hdr_ok_ff && (seen_ff < SEEN_W'(MAX_CELLS))) begin
         if (!phase_ff) begin
            pend_in  = req_data.data_byte;
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            seen_in  = seen_ff + SEEN_W'(1);
            is_cell  = 1'b1;
         end
      end
      if (req_data.last_byte) begin
         pos_in    = '0;
         hdr_ok_in = 1'b0;
         phase_in  = 1'b0;
         seen_in   = '0;
      end
   end

   // Bytes that yield no result never enter the queue.
   assign op_push         = accept && (is_cell || req_data.last_byte);
   assign op_data.is_cell = is_cell;
   assign op_data.last    = req_data.last_byte;
   assign op_data.mv      = {pend_ff, req_data.data_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         hdr_ok_ff <= 1'b0;
         phase_ff  <= 1'b0;
         seen_ff   <= '0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         hdr_ok_ff <= hdr_ok_in;
         phase_ff  <= phase_in;
         seen_ff   <= seen_in;
      end
      if (accept) begin
         pend_ff <= pend_in;
      end
   end

   // Pairing only starts once the whole echo header has gone by.
   a_phase_after_header: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (pos_ff == POS_W'(ECHO_LEN)))
      else $error("pair phase set inside the header");

endmodule

// File: rtl/cvrd_queue.sv
// Short register queue between the classifier and the statistics stage.
module cvrd_queue
   import cvrd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  cvrd_op_type push_data,
   output logic        full,
   input  logic        pop,
   output logic        not_empty,
   output cvrd_op_type head
);

   cvrd_op_type            slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_pop;

   assign full      = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + (QUEUE_PTR_W+1)'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - (QUEUE_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("item pushed into a full queue");

endmodule

// File: rtl/cvrd_back.sv
// Statistics stage: running min, max and sum, and the result output register.
module cvrd_back
   import cvrd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         op_valid,
   input  cvrd_op_type  op_data,
   output logic         op_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output cvrd_rsp_type rsp_data
);

   logic [6:0]   count_ff, count_in;
   logic [15:0]  low_ff, low_in;
   logic [15:0]  high_ff, high_in;
   logic [22:0]  sum_ff, sum_in;
   logic         cell_done_ff, cell_done_in;
   logic         rsp_valid_ff;
   cvrd_rsp_type rsp_ff, rsp_in;
   logic         load;
   logic         emit_cell;
   logic [23:0]  sum_wide;

   assign load      = op_valid && (!rsp_valid_ff || !rsp_stall);
   assign emit_cell = op_data.is_cell && !cell_done_ff;
   assign sum_wide  = {1'b0, sum_ff} + {8'd0, op_data.mv};

   always_comb begin
      count_in     = count_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      sum_in       = sum_ff;
      cell_done_in = cell_done_ff;
      rsp_in       = '0;
      op_pop       = 1'b0;
      if (load) begin
         if (emit_cell) begin
            rsp_in.cell_index = count_ff;
            rsp_in.cell_mv    = op_data.mv;
            if (count_ff == '0) begin
               low_in  = op_data.mv;
               high_in = op_data.mv;
            end else begin
               if (op_data.mv < low_ff) low_in = op_data.mv;
               if (op_data.mv > high_ff) high_in = op_data.mv;
            end
            sum_in = (sum_wide > {1'b0, SUM_LIMIT}) ? SUM_LIMIT : sum_wide[22:0];
            if (count_ff != COUNT_LIMIT) begin
               count_in = count_ff + 7'd1;
            end
            // A pair that closes the payload stays at the queue head to give its summary.
            cell_done_in = op_data.last;
            op_pop       = !op_data.last;
         end else begin
            rsp_in.is_summary = 1'b1;
            if (count_ff != '0) begin
               rsp_in.decode_ok     = 1'b1;
               rsp_in.reading_count = count_ff;
               rsp_in.min_mv        = low_ff;
               rsp_in.max_mv        = high_ff;
               rsp_in.spread_mv     = high_ff - low_ff;
               rsp_in.sum_mv        = sum_ff;
            end
            count_in     = '0;
            low_in       = '0;
            high_in      = '0;
            sum_in       = '0;
            cell_done_in = 1'b0;
            op_pop       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         low_ff       <= '0;
         high_ff      <= '0;
         sum_ff       <= '0;
         cell_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         sum_ff       <= sum_in;
         cell_done_ff <= cell_done_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_summary_clears: assert property (@(posedge clock) disable iff (reset)
      (load && !emit_cell) |=> (count_ff == '0) && (sum_ff == '0) && !cell_done_ff)
      else $error("statistics not cleared after a summary");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (low_ff <= high_ff))
      else $error("running minimum above running maximum");

   a_pending_summary: assert property (@(posedge clock) disable iff (reset)
      cell_done_ff |-> op_valid && op_data.last)
      else $error("summary pending without a last item at the queue head");

endmodule

// File: rtl/cell_voltage_response_decoder.sv
// Top level of the cell voltage response decoder.
//
// Request channel (req_valid, req_stall, req_data) carries one payload byte per
// item with a flag on the final byte. Response channel (rsp_valid, rsp_stall,
// rsp_data) returns a cell result for every completed big-endian byte pair after
// a matching echo header, up to MAX_CELLS, and a summary result after the last
// byte of each payload. csr_we/csr_wdata write the group code that byte 1 must
// echo; it resets to 2. The user must write it only while the block is idle;
// the block does not enforce it. One byte is taken every cycle unless req_stall
// is high. A result passes through the queue, then the output register. A byte
// that completes a pair and ends the payload gives a cell result, then a
// summary, in the statistics stage; the four-entry queue absorbs this, so the
// sustained rate stays at one byte per cycle unless the receiver stalls. When
// it stalls, the output register holds its result, the queue fills, and
// req_stall rises once the queue is full; no results are lost or repeated.
// Reset clears the payload state, the queue and the output valid.
module cell_voltage_response_decoder
   import cvrd_pkg::*;
#(
   parameter int ECHO_LEN  = 2,
   parameter int MAX_CELLS = 96
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [7:0]   csr_wdata,
   input  logic         req_valid,
   output logic         req_stall,
   input  cvrd_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output cvrd_rsp_type rsp_data
);

   logic [7:0]  group_ff;
   logic        op_push;
   cvrd_op_type op_in;
   logic        op_full;
   logic        op_pop;
   logic        op_valid;
   cvrd_op_type op_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff <= GROUP_RESET;
      end else if (csr_we) begin
         group_ff <= csr_wdata;
      end
   end

   cvrd_front #(
      .ECHO_LEN  (ECHO_LEN),
      .MAX_CELLS (MAX_CELLS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .expected_group (group_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .op_push        (op_push),
      .op_data        (op_in),
      .op_full        (op_full)
   );

   cvrd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_in),
      .full      (op_full),
      .pop       (op_pop),
      .not_empty (op_valid),
      .head      (op_head)
   );

   cvrd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op_data   (op_head),
      .op_pop    (op_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/cell_voltage_response_decoder_tb.sv
// Self-checking testbench for the cell voltage response decoder.
`timescale 1ns / 100ps

module cell_voltage_response_decoder_tb;
   import cvrd_pkg::*;

   localparam int ECHO_LEN      = 2;
   localparam int MAX_CELLS     = 96;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLDOFF_AT    = 300;
   localparam int HOLDOFF_LEN   = 300;
   localparam int PHASE_BYTES   = 165;
   localparam int NUM_PHASES    = 8;
   localparam int MAX_PRINTED   = 30;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic [7:0]   csr_wdata = '0;
   logic         req_valid = 1'b0;
   logic         req_stall;
   cvrd_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   cvrd_rsp_type rsp_data;

   // Stimulus waiting to be offered, and results the decoder still owes us.
   cvrd_req_type payload_bytes[$];
   cvrd_rsp_type awaited_results[$];

   // Shadow of the decoder's payload state and group register.
   logic [7:0]  group_cfg = GROUP_RESET;
   int unsigned hdr_seen;
   bit          hdr_match;
   bit          have_high;
   logic [7:0]  high_byte;
   int unsigned cell_count;
   logic [15:0] lo_mv;
   logic [15:0] hi_mv;
   int unsigned mv_total;

   // Pacing controls, written by the stimulus process.
   bit bursty = 1'b0;
   int stall_mode = 0;

   int burst_left = 0;
   int gap_left = 0;
   int stall_run = 0;
   bit stall_level = 1'b0;
   int hold_left = 0;
   bit holdoff_done = 1'b0;

   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned bytes_queued = 0;
   int unsigned bytes_accepted = 0;
   int unsigned cells_checked = 0;
   int unsigned summaries_checked = 0;
   int unsigned blocked_cycles = 0;
   int unsigned settings_used = 1;

   cell_voltage_response_decoder #(
      .ECHO_LEN  (ECHO_LEN),
      .MAX_CELLS (MAX_CELLS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report(string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("ERROR cycle %0d: %s", cycle_count, msg);
      end
   endtask

   task automatic check_field(string name, longint unsigned got, longint unsigned want);
      if (got != want) begin
         report($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   task automatic compare_result(cvrd_rsp_type got, cvrd_rsp_type want);
      if ($isunknown(got)) begin
         report($sformatf("result has unknown bits: %h", got));
      end else begin
         check_field("is_summary", got.is_summary, want.is_summary);
         check_field("cell_index", got.cell_index, want.cell_index);
         check_field("cell_mv", got.cell_mv, want.cell_mv);
         check_field("decode_ok", got.decode_ok, want.decode_ok);
         check_field("reading_count", got.reading_count, want.reading_count);
         check_field("min_mv", got.min_mv, want.min_mv);
         check_field("max_mv", got.max_mv, want.max_mv);
         check_field("spread_mv", got.spread_mv, want.spread_mv);
         check_field("sum_mv", got.sum_mv, want.sum_mv);
      end
   endtask

   function automatic logic [6:0] clamp_count(int unsigned n);
      return (n > COUNT_LIMIT) ? COUNT_LIMIT : n[6:0];
   endfunction

   function automatic void clear_payload_state();
      hdr_seen = 0;
      hdr_match = 1'b0;
      have_high = 1'b0;
      high_byte = '0;
      cell_count = 0;
      lo_mv = '0;
      hi_mv = '0;
      mv_total = 0;
   endfunction

   // Advances the shadow state by one accepted byte and queues what it causes.
   function automatic void track_payload_byte(cvrd_req_type item);
      cvrd_rsp_type res;
      logic [15:0]  mv;
      if (hdr_seen < ECHO_LEN) begin
         if (hdr_seen == 0) begin
            hdr_match = (item.data_byte == POSITIVE_RESPONSE);
         end else if (hdr_seen == 1) begin
            hdr_match = hdr_match && (item.data_byte == group_cfg);
         end
         hdr_seen++;
      end else if (hdr_match && cell_count < MAX_CELLS) begin
         if (!have_high) begin
            high_byte = item.data_byte;
            have_high = 1'b1;
         end else begin
            mv = {high_byte, item.data_byte};
            have_high = 1'b0;
            if (cell_count == 0) begin
               lo_mv = mv;
               hi_mv = mv;
            end else begin
               if (mv < lo_mv) lo_mv = mv;
               if (mv > hi_mv) hi_mv = mv;
            end
            mv_total += mv;
            if (mv_total > SUM_LIMIT) mv_total = SUM_LIMIT;
            res = '0;
            res.cell_index = clamp_count(cell_count);
            res.cell_mv = mv;
            awaited_results.push_back(res);
            cell_count++;
         end
      end
      if (item.last_byte) begin
         res = '0;
         res.is_summary = 1'b1;
         if (hdr_match && cell_count > 0) begin
            res.decode_ok = 1'b1;
            res.reading_count = clamp_count(cell_count);
            res.min_mv = lo_mv;
            res.max_mv = hi_mv;
            res.spread_mv = hi_mv - lo_mv;
            res.sum_mv = mv_total[22:0];
         end
         awaited_results.push_back(res);
         clear_payload_state();
      end
   endfunction

   function automatic void push_byte(logic [7:0] value, bit ends);
      cvrd_req_type item;
      item.data_byte = value;
      item.last_byte = ends;
      payload_bytes.push_back(item);
      bytes_queued++;
   endfunction

   // Reading bytes lean toward the extremes so that 0 and 65535 show up often.
   function automatic logic [7:0] random_byte();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void queue_response(logic [7:0] code, logic [7:0] grp, int n_cells,
                                          bit odd_tail);
      logic [7:0] bytes_out[$];
      bytes_out.push_back(code);
      bytes_out.push_back(grp);
      repeat (2 * n_cells) bytes_out.push_back(random_byte());
      if (odd_tail) bytes_out.push_back(random_byte());
      foreach (bytes_out[i]) begin
         push_byte(bytes_out[i], i == bytes_out.size() - 1);
      end
   endfunction

   function automatic void queue_random_payload();
      int pick;
      int n_cells;
      pick = $urandom_range(0, 99);
      n_cells = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
      if (pick < 65) begin
         queue_response(POSITIVE_RESPONSE, group_cfg, n_cells, $urandom_range(0, 2) == 0);
      end else if (pick < 75) begin
         queue_response(POSITIVE_RESPONSE ^ (8'h01 << $urandom_range(0, 7)), group_cfg,
                        n_cells, $urandom_range(0, 1) == 1);
      end else if (pick < 83) begin
         queue_response(POSITIVE_RESPONSE, group_cfg ^ (8'h01 << $urandom_range(0, 7)),
                        n_cells, $urandom_range(0, 1) == 1);
      end else if (pick < 90) begin
         if ($urandom_range(0, 1) == 0) begin
            push_byte(($urandom_range(0, 1) == 1) ? POSITIVE_RESPONSE : random_byte(), 1'b1);
         end else begin
            push_byte(POSITIVE_RESPONSE, 1'b0);
            push_byte(group_cfg, 1'b1);
         end
      end else begin
         // Loose bytes with random last flags; they may split or join payloads.
         repeat ($urandom_range(1, 6)) begin
            push_byte(random_byte(), $urandom_range(0, 3) == 0);
         end
      end
   endfunction

   // Waits until every item is taken and every result is in or the drain limit
   // runs out, then lets the pipeline settle so that the block is idle.
   task automatic drain_results();
      int waited;
      while (payload_bytes.size() != 0 || req_valid) @(posedge clock);
      waited = 0;
      while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0) begin
         report($sformatf("%0d expected results never arrived", awaited_results.size()));
         awaited_results.delete();
      end
   endtask

   task automatic write_group(logic [7:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      group_cfg = value;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Sender: offers queued items, in bursts separated by random gaps when bursty.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (payload_bytes.size() > 0) begin
            req_valid <= 1'b1;
            req_data <= payload_bytes.pop_front();
            if (burst_left > 0) begin
               burst_left--;
            end else if (bursty) begin
               burst_left = $urandom_range(0, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                                      : $urandom_range(1, 3);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stalls on its own pattern, with one long hold-off that lets the
   // decoder fill up and push back on its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!holdoff_done && bytes_accepted >= HOLDOFF_AT) begin
         holdoff_done = 1'b1;
         hold_left = HOLDOFF_LEN - 1;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
               if (stall_run == 0) begin
                  stall_level = !stall_level;
                  stall_run = stall_level ? $urandom_range(1, 8) : $urandom_range(1, 12);
               end else begin
                  stall_run--;
               end
               rsp_stall <= stall_level;
            end
            default: begin
               rsp_stall <= 1'b0;
            end
         endcase
      end
   end

   // Monitor: the prediction is made before the result check in the same
   // process, so a result can never overtake its own expectation.
   always @(posedge clock) begin
      if (reset) begin
         clear_payload_state();
      end else begin
         if (req_valid && !req_stall) begin
            track_payload_byte(req_data);
            bytes_accepted++;
         end
         if (req_valid && req_stall) blocked_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report($sformatf("unexpected result %h", rsp_data));
            end else begin
               compare_result(rsp_data, awaited_results.pop_front());
            end
            if (rsp_data.is_summary) summaries_checked++;
            else cells_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                  awaited_results.size());
         $display("FAIL cell_voltage_response_decoder");
         $finish;
      end
   end

   initial begin
      logic [7:0] group_plan [NUM_PHASES];
      logic [7:0] grp;
      int unsigned target;
      group_plan = '{8'h00, 8'hFF, 8'h00, POSITIVE_RESPONSE, 8'h80, GROUP_RESET, 8'h00,
                     8'h7F};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed payloads under the reset group value.
      // Extreme readings, with the last byte finishing a pair.
      push_byte(POSITIVE_RESPONSE, 1'b0);
      push_byte(GROUP_RESET, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b1);
      // Payload shorter than the header.
      push_byte(POSITIVE_RESPONSE, 1'b1);
      // Header only, so no complete pair.
      push_byte(POSITIVE_RESPONSE, 1'b0);
      push_byte(GROUP_RESET, 1'b1);
      // Wrong response code.
      push_byte(POSITIVE_RESPONSE ^ 8'h01, 1'b0);
      push_byte(GROUP_RESET, 1'b0);
      push_byte(8'h12, 1'b0);
      push_byte(8'h34, 1'b1);
      // Wrong group echo.
      push_byte(POSITIVE_RESPONSE, 1'b0);
      push_byte(GROUP_RESET ^ 8'h80, 1'b0);
      push_byte(8'h12, 1'b0);
      push_byte(8'h34, 1'b1);
      // A trailing odd byte after one reading.
      push_byte(POSITIVE_RESPONSE, 1'b0);
      push_byte(GROUP_RESET, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'h7F, 1'b1);
      drain_results();

      for (int p = 0; p < NUM_PHASES; p++) begin
         grp = (p == 2 || p == 6) ? 8'($urandom_range(0, 255)) : group_plan[p];
         write_group(grp);
         bursty <= (p % 4 != 3);
         stall_mode <= p % 3;
         target = bytes_queued + PHASE_BYTES;
         // A full-length payload that reaches the reading limit and may run past it.
         if (p == 1 || p == 5) begin
            queue_response(POSITIVE_RESPONSE, group_cfg, MAX_CELLS + $urandom_range(0, 6),
                           $urandom_range(0, 1) == 1);
         end
         while (bytes_queued < target) queue_random_payload();
         drain_results();
      end

      $display("Covered %0d payload bytes under %0d group settings:", bytes_accepted,
               settings_used);
      $display("%0d cell results and %0d summaries; input pushed back for %0d cycles.",
               cells_checked, summaries_checked, blocked_cycles);
      if (error_count == 0) begin
         $display("PASS cell_voltage_response_decoder");
      end else begin
         $display("FAIL cell_voltage_response_decoder");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/cvrd_pkg.sv
rtl/cvrd_front.sv
rtl/cvrd_queue.sv
rtl/cvrd_back.sv
rtl/cell_voltage_response_decoder.sv
tb/cell_voltage_response_decoder_tb.sv
